@@ hdl/isa_pkg.sv @@
// Shared types and codes for the interval set block.
package isa_pkg;

    // Operation codes carried on the mode field
    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FINISH,
        ST_REPLY
    } state_t;

    // Result of one item, handed from the engine to the output register
    typedef struct packed {
        logic    covered;
        status_t status;
    } result_t;

endpackage

@@ hdl/interval_set_add_remove_query.sv @@
// Interval set block: sorted table of disjoint half-open ranges with add, remove and query.
//
// Input channel (in_valid/in_ready) carries mode, range_start and range_end.
// Mode add merges every stored interval that overlaps or touches the range,
// remove trims and splits, query reports whether one interval covers the range.
// Output channel (out_valid/out_ready) returns covered, status and entry_count,
// exactly one item per input item, in order.
// One item is in work at a time. An add, remove or query goes from acceptance through
// the start state, a scan of the stored entries if there are any, the finish state and
// the reply state to the output register; the scan holds its read while a remove splits
// an entry or an add inserts its range among later entries. An empty or reversed range
// or mode three goes from the start state straight to the reply state. The table RAM
// read port streams one stored entry per cycle, except during those holds, while the
// rewritten table goes into the other bank of the same RAM.
// in_ready is high only while no item is in work; the output register holds a
// result until taken, and the next item may be accepted meanwhile. If the
// receiver stalls, that item waits in its last state until the register frees.
// Reset empties the table at once (stored count zero); no clearing pass.
module interval_set_add_remove_query
    import isa_pkg::*;
#(
    parameter int MAX_INTERVALS = 64,
    parameter int COORD_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        covered,
    output logic [1:0]  status,
    output logic [6:0]  entry_count
);

    localparam int CNT_W = $clog2(MAX_INTERVALS + 2);
    localparam int EXT_W = (CNT_W > 7) ? CNT_W : 7;

    logic [COORD_BITS-1:0] s_in, e_in;
    logic                  out_free;
    logic                  done;
    result_t               eng_res;
    logic [CNT_W-1:0]      eng_count;
    logic [EXT_W-1:0]      count_ext;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_res_reg;
    logic [6:0]            out_count_reg;

    // Fit the bounds to the coordinate width
    assign s_in = COORD_BITS'(range_start);
    assign e_in = COORD_BITS'(range_end);

    assign out_free  = !out_valid_reg || out_ready;
    assign count_ext = EXT_W'(eng_count);

    isa_engine #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .COORD_BITS   (COORD_BITS),
        .CNT_W        (CNT_W)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode    (mode),
        .s_in    (s_in),
        .e_in    (e_in),
        .out_free(out_free),
        .done    (done),
        .res     (eng_res),
        .count   (eng_count)
    );

    // Hold the result item until the receiver takes it
    always_comb
    begin
        priority if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_res_reg   <= eng_res;
            out_count_reg <= count_ext[6:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign covered     = out_res_reg.covered;
    assign status      = out_res_reg.status;
    assign entry_count = out_count_reg;

endmodule

@@ hdl/isa_tbl_ram.sv @@
// Interval table RAM: one write port, one read port with registered read data.
module isa_tbl_ram #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read the entry; the read data is registered and valid the cycle after the address
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/isa_engine.sv @@
// Sequencer and datapath: streams the table out of one bank and rewrites it into the other.
module isa_engine
    import isa_pkg::*;
#(
    parameter int MAX_INTERVALS = 64,
    parameter int COORD_BITS    = 32,
    parameter int CNT_W         = $clog2(MAX_INTERVALS + 2)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [COORD_BITS-1:0] s_in,
    input  logic [COORD_BITS-1:0] e_in,
    input  logic                  out_free,
    output logic                  done,
    output result_t               res,
    output logic [CNT_W-1:0]      count
);

    localparam int IDX_W  = $clog2(MAX_INTERVALS);
    localparam int DATA_W = 2 * COORD_BITS;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERVALS);

    state_t                state_reg, state_next;
    mode_t                 mode_reg;
    logic [COORD_BITS-1:0] s_reg, e_reg;
    logic [IDX_W-1:0]      i_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  bank_reg;
    logic                  placed_reg;
    logic                  split_reg;
    logic                  hit_reg;
    result_t               res_reg;

    logic [IDX_W:0]        rd_addr;
    logic [IDX_W:0]        wr_addr;
    logic [DATA_W-1:0]     rdata;
    logic [DATA_W-1:0]     wdata;
    logic                  we;
    logic                  ram_we;
    logic                  adv;
    logic                  merge;
    logic                  set_placed;
    logic                  set_split;
    logic                  last;
    logic                  bad;
    logic [COORD_BITS-1:0] a, b;
    logic [CNT_W-1:0]      n_fin;
    logic                  full;

    assign a     = rdata[DATA_W-1:COORD_BITS];
    assign b     = rdata[COORD_BITS-1:0];
    assign last  = (CNT_W'(i_reg) + CNT_W'(1)) == count_reg;
    assign bad   = !(s_reg < e_reg);
    assign n_fin = n_reg + CNT_W'((mode_reg == MODE_ADD) && !placed_reg);
    assign full  = n_fin > MAX_CNT;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                priority if (mode_reg == MODE_NOP || bad)
                begin
                    state_next = ST_REPLY;
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (adv && last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: table access and per-entry decisions
    always_comb
    begin
        rd_addr    = {bank_reg, i_reg};
        we         = 1'b0;
        wdata      = {s_reg, e_reg};
        adv        = 1'b0;
        merge      = 1'b0;
        set_placed = 1'b0;
        set_split  = 1'b0;
        unique case (state_reg)
            ST_START:
            begin
                rd_addr = {bank_reg, {IDX_W{1'b0}}};
            end
            ST_SCAN:
            begin
                unique case (mode_reg)
                    MODE_ADD:
                    begin
                        priority if (b < s_reg)
                        begin
                            we    = 1'b1;
                            wdata = {a, b};
                            adv   = 1'b1;
                        end
                        else if (e_reg < a)
                        begin
                            // emit the merged range once, ahead of the first later entry
                            we = 1'b1;
                            if (!placed_reg)
                            begin
                                set_placed = 1'b1;
                            end
                            else
                            begin
                                wdata = {a, b};
                                adv   = 1'b1;
                            end
                        end
                        else
                        begin
                            merge = 1'b1;
                            adv   = 1'b1;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        priority if (b <= s_reg || e_reg <= a)
                        begin
                            we    = 1'b1;
                            wdata = {a, b};
                            adv   = 1'b1;
                        end
                        else if (a < s_reg && b > e_reg && !split_reg)
                        begin
                            // left piece of a split, hold the read for the right piece
                            we        = 1'b1;
                            wdata     = {a, s_reg};
                            set_split = 1'b1;
                        end
                        else if (b > e_reg)
                        begin
                            we    = 1'b1;
                            wdata = {e_reg, b};
                            adv   = 1'b1;
                        end
                        else if (a < s_reg)
                        begin
                            we    = 1'b1;
                            wdata = {a, s_reg};
                            adv   = 1'b1;
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                    end
                    default:
                    begin
                        adv = 1'b1;
                    end
                endcase
                if (adv)
                begin
                    rd_addr = {bank_reg, i_reg + 1'b1};
                end
            end
            ST_FINISH:
            begin
                we = (mode_reg == MODE_ADD) && !placed_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign wr_addr  = {~bank_reg, n_reg[IDX_W-1:0]};
    assign ram_we   = we && (n_reg < MAX_CNT);
    assign in_ready = (state_reg == ST_IDLE);
    assign done     = (state_reg == ST_REPLY) && out_free;
    assign res      = res_reg;
    assign count    = count_reg;

    // Control state: sequencer, active bank, stored count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && !full &&
                (mode_reg == MODE_ADD || mode_reg == MODE_REMOVE))
            begin
                bank_reg  <= ~bank_reg;
                count_reg <= n_fin;
            end
        end
    end

    // Item working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                mode_reg   <= mode_t'(mode);
                s_reg      <= s_in;
                e_reg      <= e_in;
                i_reg      <= '0;
                n_reg      <= '0;
                placed_reg <= 1'b0;
                split_reg  <= 1'b0;
                hit_reg    <= 1'b0;
            end
            ST_START:
            begin
                res_reg.covered <= 1'b0;
                res_reg.status  <= bad && (mode_reg != MODE_NOP) ? STATUS_BAD : STATUS_OK;
            end
            ST_SCAN:
            begin
                if (we)
                begin
                    n_reg <= n_reg + CNT_W'(1);
                end
                if (set_placed)
                begin
                    placed_reg <= 1'b1;
                end
                if (set_split)
                begin
                    split_reg <= 1'b1;
                end
                if (merge)
                begin
                    if (a < s_reg)
                    begin
                        s_reg <= a;
                    end
                    if (b > e_reg)
                    begin
                        e_reg <= b;
                    end
                end
                if (mode_reg == MODE_QUERY && a <= s_reg && e_reg <= b)
                begin
                    hit_reg <= 1'b1;
                end
                if (adv)
                begin
                    i_reg     <= i_reg + 1'b1;
                    split_reg <= 1'b0;
                end
            end
            ST_FINISH:
            begin
                res_reg.covered <= (mode_reg == MODE_QUERY) && hit_reg;
                res_reg.status  <= (mode_reg != MODE_QUERY) && full ? STATUS_FULL : STATUS_OK;
            end
            default:
            begin
            end
        endcase
    end

    isa_tbl_ram #(
        .ADDR_W(IDX_W + 1),
        .DATA_W(DATA_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_addr),
        .wdata(wdata),
        .raddr(rd_addr),
        .rdata(rdata)
    );

endmodule

@@ hdl/isa_checker.sv @@
// Port checker for the interval set block, bound to the top level.
module isa_checker
    import isa_pkg::*;
#(
    parameter int MAX_INTERVALS = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       covered,
    input logic [1:0] status,
    input logic [6:0] entry_count
);

    // A stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(covered)
            && $stable(entry_count))
    else $error("stalled result item changed");

    // One item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

    // Covered is reported only on a clean query
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && covered |-> status == STATUS_OK)
    else $error("covered set on a flagged item");

    // Stored count never exceeds the table
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && MAX_INTERVALS < 128 |-> 32'(entry_count) <= MAX_INTERVALS)
    else $error("entry count beyond table size");

endmodule

bind interval_set_add_remove_query isa_checker #(
    .MAX_INTERVALS(MAX_INTERVALS)
) u_isa_checker (.*);
